// ----- rtl/qcd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// qcd_pkg
// Shared types, constants and the colour index hash for the QOI chunk decoder.
// ----------------------------------------------------------------------------
package qcd_pkg;

    localparam int INDEX_ENTRIES = 64;
    localparam int IDX_W         = $clog2(INDEX_ENTRIES);
    localparam int COUNT_W       = 29;
    localparam int RUN_W         = 6;

    localparam logic [1:0] OP_NONE = 2'd0;
    localparam logic [1:0] OP_RGB  = 2'd1;
    localparam logic [1:0] OP_RGBA = 2'd2;
    localparam logic [1:0] OP_LUMA = 2'd3;

    localparam logic [1:0] TAG_INDEX = 2'd0;
    localparam logic [1:0] TAG_DIFF  = 2'd1;
    localparam logic [1:0] TAG_LUMA  = 2'd2;
    localparam logic [1:0] TAG_RUN   = 2'd3;

    localparam logic [7:0] BYTE_RGB  = 8'hFE;
    localparam logic [7:0] BYTE_RGBA = 8'hFF;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
    } pixel_t;

    localparam pixel_t PIXEL_INIT = '{r: 8'd0, g: 8'd0, b: 8'd0, a: 8'd255};

    typedef struct packed {
        logic       start_of_image;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       last_of_run;
        logic       end_of_image;
        logic       status;
    } out_item_t;

    typedef struct packed {
        logic             clear;
        logic             re;
        logic [IDX_W-1:0] raddr;
        logic             we;
        logic [IDX_W-1:0] waddr;
        pixel_t           wdata;
    } mem_req_t;

    function automatic logic [IDX_W-1:0] pixel_hash(input pixel_t p);
        logic [IDX_W-1:0] h;
        h = IDX_W'(IDX_W'(p.r) * IDX_W'(3))
          + IDX_W'(IDX_W'(p.g) * IDX_W'(5))
          + IDX_W'(IDX_W'(p.b) * IDX_W'(7))
          + IDX_W'(IDX_W'(p.a) * IDX_W'(11));
        return h;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/qcd_index_mem.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// qcd_index_mem
// Colour index: one-write one-read synchronous RAM with per-entry valid bits.
// An entry not written since the last clear reads as zero.
// ----------------------------------------------------------------------------
module qcd_index_mem (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire qcd_pkg::mem_req_t req,
    output qcd_pkg::pixel_t        rdata
);

    qcd_pkg::pixel_t                       mem [qcd_pkg::INDEX_ENTRIES];
    logic [qcd_pkg::INDEX_ENTRIES-1:0]     valid_reg;
    logic [qcd_pkg::INDEX_ENTRIES-1:0]     valid_next;
    qcd_pkg::pixel_t                       rdata_reg;
    logic                                  rvalid_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (req.clear)
        begin
            valid_next = '0;
        end
        if (req.we)
        begin
            valid_next[req.waddr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (req.re)
            begin
                rvalid_reg <= valid_reg[req.raddr] && !req.clear;
            end
        end
    end

    assign rdata = rvalid_reg ? rdata_reg : '0;

endmodule
`default_nettype wire

// ----- rtl/qoi_chunk_decoder_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// qoi_chunk_decoder_top
// QOI chunk stream decoder: one stream byte per request in, one pixel per
// request out.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall, payload in_data (start_of_image, byte).
// Output channel: out_valid / out_stall, payload out_data (RGBA and flags).
// cfg_wr_en / cfg_wr_data load pixel_total; write only while idle.
// A byte that completes no pixel does not hold the input. An INDEX op first
// passes a read state (synchronous read of the colour index RAM). The first
// pixel is presented the cycle after the byte is taken (after the read state
// for INDEX).
// in_stall is high from the cycle after a pixel-producing byte until its
// last pixel has been taken; a run of up to 62 pixels holds the input.
// While the receiver stalls, the current pixel and flags hold steady.
// Reset: pixel_total = 1, previous pixel 0,0,0,255, index empty (reads 0),
// no pending op. start_of_image resets all but pixel_total in the same cycle.
// Bytes arriving after the final pixel are taken and dropped.
// ----------------------------------------------------------------------------
module qoi_chunk_decoder_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wr_en,
    input  wire logic [qcd_pkg::COUNT_W-1:0]     cfg_wr_data,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire qcd_pkg::in_item_t               in_data,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output qcd_pkg::out_item_t                   out_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]                      state_reg, state_next;
    logic [qcd_pkg::COUNT_W-1:0]     pixel_total_reg;
    qcd_pkg::pixel_t                 prev_reg, prev_next, prev_eff;
    logic [1:0]                      pend_reg, pend_next, pend_eff;
    logic [2:0]                      bl_reg, bl_next, bl_eff, pos;
    logic [7:0]                      luma_reg, luma_next, luma_eff;
    logic [qcd_pkg::COUNT_W-1:0]     pl_reg, pl_next, pl_eff;
    logic [qcd_pkg::RUN_W-1:0]       emit_left_reg, emit_left_next;
    logic                            over_reg, over_next;
    logic                            emit_go;
    logic [qcd_pkg::RUN_W-1:0]       emit_count;
    logic [7:0]                      byte_in;
    qcd_pkg::mem_req_t               mem_req;
    qcd_pkg::pixel_t                 mem_rdata;

    qcd_index_mem u_index (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    assign byte_in = in_data.data_byte;

    always_comb
    begin
        state_next     = state_reg;
        prev_next      = prev_reg;
        pend_next      = pend_reg;
        bl_next        = bl_reg;
        luma_next      = luma_reg;
        pl_next        = pl_reg;
        emit_left_next = emit_left_reg;
        over_next      = over_reg;
        emit_go        = 1'b0;
        emit_count     = qcd_pkg::RUN_W'(1);
        mem_req        = '0;
        mem_req.raddr  = byte_in[qcd_pkg::IDX_W-1:0];
        prev_eff       = prev_reg;
        pend_eff       = pend_reg;
        bl_eff         = bl_reg;
        luma_eff       = luma_reg;
        pl_eff         = pl_reg;
        pos            = 3'd0;

        if (in_data.start_of_image)
        begin
            prev_eff = qcd_pkg::PIXEL_INIT;
            pend_eff = qcd_pkg::OP_NONE;
            bl_eff   = 3'd0;
            luma_eff = 8'd0;
            pl_eff   = pixel_total_reg;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    mem_req.clear = in_data.start_of_image;
                    prev_next     = prev_eff;
                    pend_next     = pend_eff;
                    bl_next       = bl_eff;
                    luma_next     = luma_eff;
                    pl_next       = pl_eff;
                    if (pl_eff != '0)
                    begin
                        priority if (pend_eff == qcd_pkg::OP_RGB
                                     || pend_eff == qcd_pkg::OP_RGBA)
                        begin
                            pos = ((pend_eff == qcd_pkg::OP_RGB) ? 3'd3 : 3'd4) - bl_eff;
                            unique case (pos)
                                3'd0:    prev_next.r = byte_in;
                                3'd1:    prev_next.g = byte_in;
                                3'd2:    prev_next.b = byte_in;
                                default: prev_next.a = byte_in;
                            endcase
                            bl_next = bl_eff - 3'd1;
                            if (bl_next == 3'd0)
                            begin
                                pend_next = qcd_pkg::OP_NONE;
                                emit_go   = 1'b1;
                            end
                        end
                        else if (pend_eff == qcd_pkg::OP_LUMA)
                        begin
                            prev_next.r = prev_eff.r + luma_eff + 8'd248
                                        + {4'd0, byte_in[7:4]};
                            prev_next.g = prev_eff.g + luma_eff;
                            prev_next.b = prev_eff.b + luma_eff + 8'd248
                                        + {4'd0, byte_in[3:0]};
                            pend_next   = qcd_pkg::OP_NONE;
                            bl_next     = 3'd0;
                            emit_go     = 1'b1;
                        end
                        else if (byte_in == qcd_pkg::BYTE_RGB)
                        begin
                            pend_next = qcd_pkg::OP_RGB;
                            bl_next   = 3'd3;
                        end
                        else if (byte_in == qcd_pkg::BYTE_RGBA)
                        begin
                            pend_next = qcd_pkg::OP_RGBA;
                            bl_next   = 3'd4;
                        end
                        else
                        begin
                            unique case (byte_in[7:6])
                                qcd_pkg::TAG_INDEX:
                                begin
                                    mem_req.re = 1'b1;
                                    state_next = ST_READ;
                                end
                                qcd_pkg::TAG_DIFF:
                                begin
                                    prev_next.r = prev_eff.r + {6'd0, byte_in[5:4]} + 8'd254;
                                    prev_next.g = prev_eff.g + {6'd0, byte_in[3:2]} + 8'd254;
                                    prev_next.b = prev_eff.b + {6'd0, byte_in[1:0]} + 8'd254;
                                    emit_go     = 1'b1;
                                end
                                qcd_pkg::TAG_LUMA:
                                begin
                                    luma_next = {2'd0, byte_in[5:0]} + 8'd224;
                                    pend_next = qcd_pkg::OP_LUMA;
                                    bl_next   = 3'd1;
                                end
                                default:
                                begin
                                    emit_count = byte_in[5:0] + qcd_pkg::RUN_W'(1);
                                    emit_go    = 1'b1;
                                end
                            endcase
                        end
                    end
                end
            end
            ST_READ:
            begin
                prev_next = mem_rdata;
                emit_go   = 1'b1;
            end
            ST_EMIT:
            begin
                if (!out_stall)
                begin
                    pl_next        = pl_reg - qcd_pkg::COUNT_W'(1);
                    emit_left_next = emit_left_reg - qcd_pkg::RUN_W'(1);
                    if (emit_left_reg == qcd_pkg::RUN_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (emit_go)
        begin
            mem_req.we    = 1'b1;
            mem_req.waddr = qcd_pkg::pixel_hash(prev_next);
            mem_req.wdata = prev_next;
            over_next     = qcd_pkg::COUNT_W'(emit_count) > pl_next;
            emit_left_next = over_next ? pl_next[qcd_pkg::RUN_W-1:0] : emit_count;
            state_next    = ST_EMIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            pixel_total_reg <= qcd_pkg::COUNT_W'(1);
            prev_reg        <= qcd_pkg::PIXEL_INIT;
            pend_reg        <= qcd_pkg::OP_NONE;
            bl_reg          <= 3'd0;
            luma_reg        <= 8'd0;
            pl_reg          <= qcd_pkg::COUNT_W'(1);
            emit_left_reg   <= '0;
            over_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            prev_reg      <= prev_next;
            pend_reg      <= pend_next;
            bl_reg        <= bl_next;
            luma_reg      <= luma_next;
            pl_reg        <= pl_next;
            emit_left_reg <= emit_left_next;
            over_reg      <= over_next;
            if (cfg_wr_en)
            begin
                pixel_total_reg <= cfg_wr_data;
            end
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_EMIT);

    always_comb
    begin
        out_data.red          = prev_reg.r;
        out_data.green        = prev_reg.g;
        out_data.blue         = prev_reg.b;
        out_data.alpha        = prev_reg.a;
        out_data.last_of_run  = (emit_left_reg == qcd_pkg::RUN_W'(1));
        out_data.end_of_image = (pl_reg == qcd_pkg::COUNT_W'(1));
        out_data.status       = out_data.last_of_run && over_reg;
    end

    // an emitted pixel always has image budget left
    a_emit_budget: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pl_reg != '0) && (emit_left_reg != '0))
        else $error("pixel emitted with no budget");

    // overrun flag only on the final pixel of the image
    a_status_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status |-> out_data.end_of_image && out_data.last_of_run)
        else $error("overrun flag off the final pixel");

    // final pixel taken leaves nothing to emit
    a_eoi_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && out_data.end_of_image |=>
            (pl_reg == '0) && (state_reg == ST_IDLE))
        else $error("decoder still busy after final pixel");

    // index read and write never share a cycle
    a_mem_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_req.re && mem_req.we))
        else $error("index read and write collide");

    // index read completes into an emit
    a_read_emit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_READ |=> state_reg == ST_EMIT)
        else $error("index read not followed by emit");

endmodule
`default_nettype wire

// ----- test/tb_qoi_chunk_decoder_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_qoi_chunk_decoder_top
// Self-checking bench for the QOI chunk decoder. Stream bytes go in one
// request at a time. A behavioral decoder in the bench tracks the colour
// index, the previous pixel and the pixel count. It queues the pixels that
// each byte must produce, and every pixel that comes out is compared field
// by field against the oldest one queued. Directed ops, image restarts,
// runs past the end and a long receiver hold-off come first, then random
// images under varying sender and receiver idling.
// ----------------------------------------------------------------------------
module tb_qoi_chunk_decoder_top;

    localparam int SETTLE_CYCLES = 6;
    localparam int LONG_HOLD     = 300;

    logic                         clk         = 1'b0;
    logic                         rst_n       = 1'b0;
    logic                         cfg_wr_en   = 1'b0;
    logic [qcd_pkg::COUNT_W-1:0]  cfg_wr_data = '0;
    logic                         in_valid    = 1'b0;
    logic                         in_stall;
    qcd_pkg::in_item_t            in_data     = '0;
    logic                         out_valid;
    logic                         out_stall   = 1'b0;
    qcd_pkg::out_item_t           out_data;

    int in_idle_pct  = 26;
    int out_idle_pct = 87;
    int holds_requested = 0;
    int holds_started   = 0;
    int hold_left       = 0;

    int mismatch_count = 0;
    int pixels_seen    = 0;
    int decoded_bytes  = 0;

    // decoder state as seen by the bench
    qcd_pkg::pixel_t              colour_tbl [qcd_pkg::INDEX_ENTRIES];
    qcd_pkg::pixel_t              cur_px;
    logic [1:0]                   op_pending;
    logic [2:0]                   chan_left;
    logic [7:0]                   luma_dg;
    logic [qcd_pkg::COUNT_W-1:0]  px_left;
    logic [qcd_pkg::COUNT_W-1:0]  total_reg;
    logic [qcd_pkg::IDX_W-1:0]    recent_slots [8];
    logic [2:0]                   recent_wr = '0;

    qcd_pkg::out_item_t           pending_pixels [$];
    qcd_pkg::out_item_t           pixel_want;

    qoi_chunk_decoder_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // receiver: random stalls, plus long hold-offs on request
    always @(posedge clk)
    begin
        if (holds_requested != holds_started)
        begin
            holds_started <= holds_started + 1;
            hold_left     <= LONG_HOLD - 1;
            out_stall     <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= out_idle_pct != 0 && $urandom_range(99) < out_idle_pct;
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 40)
            $display("ERROR @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("pixel %0d %s: got %h, expected %h",
                                      pixels_seen, name, got, want));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_pixels.size() == 0)
                report_mismatch($sformatf("pixel %0d (%h) with nothing pending",
                                          pixels_seen, out_data));
            else
            begin
                pixel_want = pending_pixels.pop_front();
                check_field("red",          out_data.red,          pixel_want.red);
                check_field("green",        out_data.green,        pixel_want.green);
                check_field("blue",         out_data.blue,         pixel_want.blue);
                check_field("alpha",        out_data.alpha,        pixel_want.alpha);
                check_field("last_of_run",  out_data.last_of_run,  pixel_want.last_of_run);
                check_field("end_of_image", out_data.end_of_image, pixel_want.end_of_image);
                check_field("status",       out_data.status,       pixel_want.status);
            end
            pixels_seen++;
        end
    end

    function automatic logic [qcd_pkg::IDX_W-1:0] slot_of(input qcd_pkg::pixel_t p);
        int unsigned h;
        h = p.r * 3 + p.g * 5 + p.b * 7 + p.a * 11;
        return h[qcd_pkg::IDX_W-1:0];
    endfunction

    task automatic restart_image();
        foreach (colour_tbl[i])
            colour_tbl[i] = '0;
        cur_px     = '{r: 8'd0, g: 8'd0, b: 8'd0, a: 8'd255};
        op_pending = qcd_pkg::OP_NONE;
        chan_left  = '0;
        luma_dg    = '0;
    endtask

    // store the current pixel, then queue it count times, clipped at image end
    task automatic emit_pixels(input int unsigned count);
        int unsigned        n;
        bit                 over;
        qcd_pkg::out_item_t e;
        colour_tbl[slot_of(cur_px)] = cur_px;
        recent_slots[recent_wr] = slot_of(cur_px);
        recent_wr++;
        n    = count;
        over = 1'b0;
        if (n > px_left)
        begin
            n    = px_left;
            over = 1'b1;
        end
        for (int i = 0; i < n; i++)
        begin
            e.red          = cur_px.r;
            e.green        = cur_px.g;
            e.blue         = cur_px.b;
            e.alpha        = cur_px.a;
            e.last_of_run  = (i + 1 == n);
            e.end_of_image = e.last_of_run && (px_left - n == 0);
            e.status       = e.last_of_run && over;
            pending_pixels.push_back(e);
        end
        px_left = px_left - n;
    endtask

    task automatic decode_byte(input logic sof, input logic [7:0] value);
        int pos;
        if (sof)
        begin
            restart_image();
            px_left = total_reg;
        end
        if (px_left == 0)
            return;
        decoded_bytes++;
        if (op_pending == qcd_pkg::OP_RGB || op_pending == qcd_pkg::OP_RGBA)
        begin
            pos = (op_pending == qcd_pkg::OP_RGB ? 3 : 4) - chan_left;
            case (pos)
                0:       cur_px.r = value;
                1:       cur_px.g = value;
                2:       cur_px.b = value;
                default: cur_px.a = value;
            endcase
            chan_left--;
            if (chan_left == 0)
            begin
                op_pending = qcd_pkg::OP_NONE;
                emit_pixels(1);
            end
            return;
        end
        if (op_pending == qcd_pkg::OP_LUMA)
        begin
            cur_px.r   = cur_px.r + luma_dg + 8'd248 + value[7:4];
            cur_px.g   = cur_px.g + luma_dg;
            cur_px.b   = cur_px.b + luma_dg + 8'd248 + value[3:0];
            op_pending = qcd_pkg::OP_NONE;
            chan_left  = '0;
            emit_pixels(1);
            return;
        end
        if (value == qcd_pkg::BYTE_RGB)
        begin
            op_pending = qcd_pkg::OP_RGB;
            chan_left  = 3'd3;
            return;
        end
        if (value == qcd_pkg::BYTE_RGBA)
        begin
            op_pending = qcd_pkg::OP_RGBA;
            chan_left  = 3'd4;
            return;
        end
        case (value[7:6])
            qcd_pkg::TAG_INDEX:
            begin
                cur_px = colour_tbl[value[5:0]];
                emit_pixels(1);
            end
            qcd_pkg::TAG_DIFF:
            begin
                cur_px.r = cur_px.r + value[5:4] + 8'd254;
                cur_px.g = cur_px.g + value[3:2] + 8'd254;
                cur_px.b = cur_px.b + value[1:0] + 8'd254;
                emit_pixels(1);
            end
            qcd_pkg::TAG_LUMA:
            begin
                luma_dg    = value[5:0] + 8'd224;
                op_pending = qcd_pkg::OP_LUMA;
                chan_left  = 3'd1;
            end
            default:
                emit_pixels(value[5:0] + 1);
        endcase
    endtask

    task automatic send_byte(input logic sof, input logic [7:0] value);
        while (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{start_of_image: sof, data_byte: value};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        decode_byte(sof, value);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_pixel_total(input logic [qcd_pkg::COUNT_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        @(posedge clk);
        total_reg = value;
    endtask

    task automatic send_random_op(input logic sof);
        int unsigned               kind;
        logic [qcd_pkg::IDX_W-1:0] slot;
        logic [5:0]                run_len;
        kind = $urandom_range(99);
        if (kind < 18)
        begin
            slot = $urandom_range(1) ? recent_slots[$urandom_range(7)]
                                     : qcd_pkg::IDX_W'($urandom);
            send_byte(sof, {qcd_pkg::TAG_INDEX, slot});
        end
        else if (kind < 40)
            send_byte(sof, {qcd_pkg::TAG_DIFF, 6'($urandom)});
        else if (kind < 58)
        begin
            send_byte(sof, {qcd_pkg::TAG_LUMA, 6'($urandom)});
            send_byte(1'b0, 8'($urandom));
        end
        else if (kind < 75)
        begin
            run_len = ($urandom_range(9) == 0) ? 6'($urandom_range(61))
                                               : 6'($urandom_range(7));
            send_byte(sof, {qcd_pkg::TAG_RUN, run_len});
        end
        else if (kind < 88)
        begin
            send_byte(sof, qcd_pkg::BYTE_RGB);
            repeat (3) send_byte(1'b0, 8'($urandom));
        end
        else
        begin
            send_byte(sof, qcd_pkg::BYTE_RGBA);
            repeat (4) send_byte(1'b0, 8'($urandom));
        end
    endtask

    // reset leaves a one-pixel image; later bytes are dropped
    task automatic test_after_reset();
        send_byte(1'b0, {qcd_pkg::TAG_DIFF, 6'h00});
        send_byte(1'b0, {qcd_pkg::TAG_DIFF, 6'h3F});
        drain();
    endtask

    task automatic test_all_ops();
        logic [qcd_pkg::IDX_W-1:0] rgb_slot;
        set_pixel_total(29'd80);
        send_byte(1'b1, qcd_pkg::BYTE_RGB);
        send_byte(1'b0, 8'h00);
        send_byte(1'b0, 8'hFF);
        send_byte(1'b0, 8'h80);
        rgb_slot = slot_of(cur_px);
        send_byte(1'b0, qcd_pkg::BYTE_RGBA);
        send_byte(1'b0, 8'h12);
        send_byte(1'b0, 8'h34);
        send_byte(1'b0, 8'h56);
        send_byte(1'b0, 8'h00);
        send_byte(1'b0, {qcd_pkg::TAG_INDEX, slot_of(cur_px)});
        send_byte(1'b0, {qcd_pkg::TAG_INDEX, rgb_slot});
        send_byte(1'b0, {qcd_pkg::TAG_DIFF, 6'h00});
        send_byte(1'b0, {qcd_pkg::TAG_DIFF, 6'h3F});
        send_byte(1'b0, {qcd_pkg::TAG_LUMA, 6'h00});
        send_byte(1'b0, 8'h00);
        send_byte(1'b0, {qcd_pkg::TAG_LUMA, 6'h3F});
        send_byte(1'b0, 8'hFF);
        send_byte(1'b0, {qcd_pkg::TAG_RUN, 6'd0});
        send_byte(1'b0, {qcd_pkg::TAG_RUN, 6'd61});
        // 9 pixels remain, the run asks for 16
        send_byte(1'b0, {qcd_pkg::TAG_RUN, 6'd15});
        drain();
    endtask

    // restart in the middle of an RGB op, then change the total mid-image
    task automatic test_restart_and_zero_total();
        set_pixel_total(29'd3);
        send_byte(1'b1, qcd_pkg::BYTE_RGB);
        send_byte(1'b0, 8'h11);
        send_byte(1'b1, {qcd_pkg::TAG_DIFF, 6'h3F});
        drain();
        set_pixel_total(29'd0);
        send_byte(1'b0, {qcd_pkg::TAG_DIFF, 6'h01});
        send_byte(1'b1, {qcd_pkg::TAG_DIFF, 6'h02});
        send_byte(1'b0, {qcd_pkg::TAG_RUN, 6'd5});
        drain();
    endtask

    task automatic test_max_total();
        set_pixel_total({qcd_pkg::COUNT_W{1'b1}});
        send_byte(1'b1, {qcd_pkg::TAG_RUN, 6'd61});
        send_byte(1'b0, {qcd_pkg::TAG_DIFF, 6'h15});
        drain();
    endtask

    // receiver holds off while the sender keeps offering bytes
    task automatic test_output_backpressure();
        set_pixel_total(29'd150);
        @(negedge clk);
        holds_requested = holds_requested + 1;
        @(posedge clk);
        send_byte(1'b1, {qcd_pkg::TAG_DIFF, 6'h2A});
        repeat (16) send_random_op(1'b0);
        drain();
    endtask

    task automatic test_random_stream(input int sender_pct, input int receiver_pct,
                                      input int unsigned quota);
        int unsigned stop_at;
        int unsigned roll;
        in_idle_pct  = sender_pct;
        out_idle_pct = receiver_pct;
        stop_at = decoded_bytes + quota;
        while (decoded_bytes < stop_at)
        begin
            if (total_reg == 0 || $urandom_range(9) < 7)
            begin
                drain();
                roll = $urandom_range(99);
                if (roll < 8)
                    set_pixel_total(29'd1);
                else if (roll < 11)
                    set_pixel_total(29'd0);
                else
                    set_pixel_total(qcd_pkg::COUNT_W'($urandom_range(40, 2)));
            end
            send_random_op(1'b1);
            while (px_left != 0 && decoded_bytes < stop_at)
            begin
                roll = $urandom_range(99);
                if (roll < 4)
                    send_byte(1'b0, 8'($urandom));
                else if (roll < 7)
                    send_random_op(1'b1);
                else
                    send_random_op(1'b0);
            end
            if ($urandom_range(3) == 0)
                send_byte(1'b0, 8'($urandom));
        end
    endtask

    initial
    begin
        restart_image();
        total_reg = 29'd1;
        px_left   = 29'd1;
        foreach (recent_slots[i])
            recent_slots[i] = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_after_reset();
        test_all_ops();
        test_restart_and_zero_total();
        test_max_total();
        test_output_backpressure();
        test_random_stream(26, 87, 100);
        test_random_stream(87, 26, 100);
        test_random_stream(0, 0, 100);
        drain();

        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
